[hdl/apsp_pkg.sv]
// Shared constants, types and helpers for the all-pairs shortest path block.
`timescale 1ns / 1ps
`default_nettype none

package apsp_pkg;

    // Matrix geometry
    localparam int NODES       = 16;
    localparam int WEIGHT_BITS = 16;
    localparam int CELLS       = NODES * NODES;
    localparam int IDX_BITS    = $clog2(NODES);
    localparam int ADDR_BITS   = $clog2(CELLS);

    // Field widths fixed by the interface
    localparam int WEIGHT_W    = 16;
    localparam int NODE_W      = 4;
    localparam int DIST_W      = 21;
    localparam int STORE_BITS  = 20;

    localparam logic [STORE_BITS-1:0] STORE_MAX = '1;

    // Low WEIGHT_BITS bits of the weight field are kept
    localparam logic [WEIGHT_W-1:0] WEIGHT_MASK =
        (WEIGHT_BITS >= WEIGHT_W) ? {WEIGHT_W{1'b1}} : WEIGHT_W'((1 << WEIGHT_BITS) - 1);

    // Operation codes carried on the input tuser bit
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic load_wr;   // write next load weight
        logic query_rd;  // read the queried pair
        logic out_load;  // form the answer in the output register
        logic ik_rd;     // read d[i][k]
        logic ik_chk;    // latch d[i][k]
        logic j_rd;      // read d[k][j] and d[i][j]
        logic j_upd;     // relax d[i][j], step j
        logic adv_i;     // next row (and next relay after the last row)
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic load_last; // load position at the final cell
        logic out_free;  // output register can take an answer
        logic ik_zero;   // d[i][k] is zero
        logic j_last;
        logic i_last;
        logic k_last;
    } ctrl_status_t;

    // Row-major cell address
    function automatic logic [ADDR_BITS-1:0] cell_addr(input logic [IDX_BITS-1:0] row,
                                                       input logic [IDX_BITS-1:0] col);
        cell_addr = ADDR_BITS'(32'(row) * NODES + 32'(col));
    endfunction

endpackage

`default_nettype wire

[hdl/apsp_datapath.sv]
// Datapath: distance memory, loop counters, relaxation arithmetic and output register.
`timescale 1ns / 1ps
`default_nettype none

module apsp_datapath
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire apsp_pkg::ctrl_cmd_t           cmd,
    output apsp_pkg::ctrl_status_t             status,
    input  wire logic [apsp_pkg::WEIGHT_W-1:0] weight,
    input  wire logic [apsp_pkg::NODE_W-1:0]   src_node,
    input  wire logic [apsp_pkg::NODE_W-1:0]   dst_node,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               path_found,
    output logic signed [apsp_pkg::DIST_W-1:0] distance
);
    import apsp_pkg::*;

    logic [STORE_BITS-1:0] mem [CELLS];

    logic [ADDR_BITS-1:0]  load_pos_reg;
    logic [IDX_BITS-1:0]   k_reg;
    logic [IDX_BITS-1:0]   i_reg;
    logic [IDX_BITS-1:0]   j_reg;
    logic [STORE_BITS-1:0] rd_a_reg;
    logic [STORE_BITS-1:0] rd_b_reg;
    logic [STORE_BITS-1:0] ik_reg;
    logic                  q_ok_reg;
    logic                  out_valid_reg;
    logic                  found_reg;
    logic signed [DIST_W-1:0] dist_reg;

    logic [ADDR_BITS-1:0]  query_addr;
    logic [ADDR_BITS-1:0]  rd_a_addr;
    logic [ADDR_BITS-1:0]  ij_addr;
    logic                  query_ok;
    logic [STORE_BITS:0]   sum;
    logic [STORE_BITS-1:0] via;
    logic                  relax_wr;
    logic [STORE_BITS-1:0] answer;

    // Query address and range check
    assign query_addr = cell_addr(IDX_BITS'(src_node), IDX_BITS'(dst_node));
    assign query_ok   = (32'(src_node) < NODES) && (32'(dst_node) < NODES) &&
                        (src_node != dst_node);

    // Read port A serves queries, d[i][k] and d[k][j]; port B serves d[i][j]
    always_comb
    begin
        if (cmd.query_rd)
            rd_a_addr = query_addr;
        else if (cmd.ik_rd)
            rd_a_addr = cell_addr(i_reg, k_reg);
        else
            rd_a_addr = cell_addr(k_reg, j_reg);
    end
    assign ij_addr = cell_addr(i_reg, j_reg);

    // Relay sum with saturation, then the relaxation decision
    assign sum = {1'b0, ik_reg} + {1'b0, rd_a_reg};
    assign via = sum[STORE_BITS] ? STORE_MAX : sum[STORE_BITS-1:0];
    always_comb
    begin
        relax_wr = 1'b0;
        if (rd_a_reg != '0)
        begin
            if (rd_b_reg != '0)
                relax_wr = (via < rd_b_reg);
            else
                relax_wr = (i_reg != j_reg);
        end
    end

    // Distance memory
    always_ff @(posedge clk)
    begin
        if (cmd.load_wr)
            mem[load_pos_reg] <= STORE_BITS'(weight & WEIGHT_MASK);
        else if (cmd.j_upd && relax_wr)
            mem[ij_addr] <= via;
        if (cmd.query_rd || cmd.ik_rd || cmd.j_rd)
            rd_a_reg <= mem[rd_a_addr];
        if (cmd.j_rd)
            rd_b_reg <= mem[ij_addr];
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.ik_chk)
            ik_reg <= rd_a_reg;
        if (cmd.query_rd)
            q_ok_reg <= query_ok;
    end

    // Load position and closure loop counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_pos_reg <= '0;
            k_reg        <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
        end
        else
        begin
            if (cmd.load_wr)
                load_pos_reg <= status.load_last ? '0 : load_pos_reg + 1'b1;
            if (cmd.adv_i)
            begin
                j_reg <= '0;
                if (status.i_last)
                begin
                    i_reg <= '0;
                    k_reg <= status.k_last ? '0 : k_reg + 1'b1;
                end
                else
                begin
                    i_reg <= i_reg + 1'b1;
                end
            end
            else if (cmd.j_upd)
            begin
                j_reg <= status.j_last ? '0 : j_reg + 1'b1;
            end
        end
    end

    // Output register
    assign answer = q_ok_reg ? rd_a_reg : '0;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            found_reg <= (answer != '0);
            dist_reg  <= (answer != '0) ? $signed({1'b0, answer}) : '1;
        end
    end

    assign out_valid  = out_valid_reg;
    assign path_found = found_reg;
    assign distance   = dist_reg;

    // Status back to the controller
    assign status.load_last = (load_pos_reg == ADDR_BITS'(CELLS - 1));
    assign status.out_free  = !out_valid_reg || out_ready;
    assign status.ik_zero   = (rd_a_reg == '0);
    assign status.j_last    = (j_reg == IDX_BITS'(NODES - 1));
    assign status.i_last    = (i_reg == IDX_BITS'(NODES - 1));
    assign status.k_last    = (k_reg == IDX_BITS'(NODES - 1));

endmodule

`default_nettype wire

[hdl/apsp_ctrl.sv]
// Controller: request acceptance, query answer timing and the closure sequencer.
`timescale 1ns / 1ps
`default_nettype none

module apsp_ctrl
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  operation,
    output apsp_pkg::ctrl_cmd_t        cmd,
    input  wire apsp_pkg::ctrl_status_t status
);
    import apsp_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_Q_OUT,
        ST_IK_RD,
        ST_IK_CHK,
        ST_J_RD,
        ST_J_UPD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;
    logic   accept;
    logic   closure_done;

    assign accept       = in_valid && ready_reg;
    assign closure_done = status.i_last && status.k_last;

    // Commands and next state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (operation == OP_LOAD)
                    begin
                        cmd.load_wr = 1'b1;
                        if (status.load_last)
                            state_next = ST_IK_RD;
                    end
                    else
                    begin
                        cmd.query_rd = 1'b1;
                        state_next   = ST_Q_OUT;
                    end
                end
            end
            ST_Q_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_IK_RD:
            begin
                cmd.ik_rd  = 1'b1;
                state_next = ST_IK_CHK;
            end
            ST_IK_CHK:
            begin
                cmd.ik_chk = 1'b1;
                if (status.ik_zero)
                begin
                    cmd.adv_i  = 1'b1;
                    state_next = closure_done ? ST_IDLE : ST_IK_RD;
                end
                else
                begin
                    state_next = ST_J_RD;
                end
            end
            ST_J_RD:
            begin
                cmd.j_rd   = 1'b1;
                state_next = ST_J_UPD;
            end
            ST_J_UPD:
            begin
                cmd.j_upd = 1'b1;
                if (status.j_last)
                begin
                    cmd.adv_i  = 1'b1;
                    state_next = closure_done ? ST_IDLE : ST_IK_RD;
                end
                else
                begin
                    state_next = ST_J_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == ST_IDLE);
        end
    end

    assign in_ready = ready_reg;

    // Checks
    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("answer loaded into a busy output register");

    a_query_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.query_rd |=> (state_reg == ST_Q_OUT))
        else $error("query request not followed by answer state");

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == ST_IDLE))
        else $error("request taken outside idle");

    a_last_load_closure: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_wr && status.load_last) |=> (state_reg == ST_IK_RD) && !in_ready)
        else $error("closure did not start after the final load");

endmodule

`default_nettype wire

[hdl/all_pairs_shortest_path.sv]
// Top level of the all-pairs shortest path block: stream ports, controller and datapath.
//
// Input stream (s_*): one request per accepted beat. s_tuser = 0 loads the next
// weight of the NODES x NODES matrix in row-major order (0 means no edge);
// s_tuser = 1 queries the pair (src_node, dst_node).
// Output stream (m_*): one answer per query, none per load: path_found and the
// shortest distance, or -1 when there is no route or the nodes are equal.
// Successive loads are taken back to back. A query reads the memory when taken,
// and its answer is loaded into the output register once that is free; s_tready
// stays low until then. After the final load of a matrix the Floyd-Warshall
// closure runs in place, with s_tready low: for each relay and row, d[i][k] is
// read and checked (ST_IK_RD, ST_IK_CHK), and when that is nonzero each column
// is read from memory (ST_J_RD) and then relaxed and written (ST_J_UPD). The
// distance memory has a single write port and two read ports.
// Reset clears the load position and the handshake state; the matrix contents
// are undefined until loaded. When m_tready is low an answer waits in the
// output register; a further load is still taken, and a further query is taken
// but then holds s_tready low until the register is free.
`timescale 1ns / 1ps
`default_nettype none

module all_pairs_shortest_path
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // weight[15:0], src_node[19:16], dst_node[23:20]
    input  wire logic        s_tuser,   // operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // path_found[0], distance[21:1], zero pad[23:22]
);
    import apsp_pkg::*;

    ctrl_cmd_t              cmd;
    ctrl_status_t           status;
    logic                   path_found;
    logic signed [DIST_W-1:0] distance;

    // Sequencer
    apsp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .operation (s_tuser),
        .cmd       (cmd),
        .status    (status)
    );

    // Memory and arithmetic
    apsp_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .weight     (s_tdata[15:0]),
        .src_node   (s_tdata[19:16]),
        .dst_node   (s_tdata[23:20]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .path_found (path_found),
        .distance   (distance)
    );

    // Answer packing
    assign m_tdata = {2'b00, distance, path_found};

endmodule

`default_nettype wire

[verif/apsp_answer_checker.sv]
// Checker for the all-pairs shortest path block: predicts query answers and compares them.
`timescale 1ns / 1ps

module apsp_answer_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [23:0] s_tdata,   // weight[15:0], src_node[19:16], dst_node[23:20]
    input  wire logic        s_tuser,   // operation
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [23:0] m_tdata,   // path_found[0], distance[21:1], zero pad[23:22]
    output int               fail_count,
    output int               pending
);
    import apsp_pkg::*;

    typedef struct packed {
        logic              found;
        logic [DIST_W-1:0] distance;
    } answer_t;

    // Own copy of the distance matrix and the load pointer
    logic [STORE_BITS-1:0] dist_mx [CELLS];
    int unsigned           next_cell;
    answer_t               answers_due [$];

    // Relay sum, saturating at the store width
    function automatic logic [STORE_BITS-1:0] relay_sum(input logic [STORE_BITS-1:0] a,
                                                        input logic [STORE_BITS-1:0] b);
        logic [STORE_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        relay_sum = s[STORE_BITS] ? STORE_MAX : s[STORE_BITS-1:0];
    endfunction

    // Floyd-Warshall pass in place; d[i][k] is fetched once per row
    task automatic close_paths();
        logic [STORE_BITS-1:0] via_ik;
        logic [STORE_BITS-1:0] via_kj;
        logic [STORE_BITS-1:0] via;
        for (int k = 0; k < NODES; k++)
        begin
            for (int i = 0; i < NODES; i++)
            begin
                via_ik = dist_mx[i*NODES + k];
                if (via_ik != '0)
                begin
                    for (int j = 0; j < NODES; j++)
                    begin
                        via_kj = dist_mx[k*NODES + j];
                        if (via_kj != '0)
                        begin
                            via = relay_sum(via_ik, via_kj);
                            if (dist_mx[i*NODES + j] != '0)
                            begin
                                if (via < dist_mx[i*NODES + j])
                                    dist_mx[i*NODES + j] = via;
                            end
                            else if (i != j)
                                dist_mx[i*NODES + j] = via;
                        end
                    end
                end
            end
        end
    endtask

    // Apply one accepted request; a query queues its answer
    task automatic take_request(input logic op, input logic [23:0] data);
        logic [WEIGHT_W-1:0]   w;
        int                    src;
        int                    dst;
        logic [STORE_BITS-1:0] v;
        answer_t               a;
        if (op == OP_LOAD)
        begin
            w = data[15:0] & WEIGHT_MASK;
            dist_mx[next_cell] = STORE_BITS'(w);
            next_cell++;
            if (next_cell >= CELLS)
            begin
                close_paths();
                next_cell = 0;
            end
        end
        else
        begin
            src = data[19:16];
            dst = data[23:20];
            v   = '0;
            if (src < NODES && dst < NODES && src != dst)
                v = dist_mx[src*NODES + dst];
            a.found    = (v != '0);
            a.distance = (v == '0) ? {DIST_W{1'b1}} : DIST_W'(v);
            answers_due.push_back(a);
        end
    endtask

    // Answers are retired before requests: an answer never belongs to a query taken
    // at the same edge
    always @(posedge clk)
    begin
        answer_t due;
        if (!rst_n)
        begin
            next_cell = 0;
            answers_due.delete();
            foreach (dist_mx[c])
                dist_mx[c] = '0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (answers_due.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: answer with none due: path_found=%0b distance=%0d",
                             $time, m_tdata[0], $signed(m_tdata[21:1]));
                end
                else
                begin
                    due = answers_due.pop_front();
                    if (m_tdata[0] !== due.found)
                    begin
                        fail_count++;
                        $display("%0t: path_found expected %0b got %0b",
                                 $time, due.found, m_tdata[0]);
                    end
                    if (m_tdata[21:1] !== due.distance)
                    begin
                        fail_count++;
                        $display("%0t: distance expected %0d got %0d",
                                 $time, $signed(due.distance), $signed(m_tdata[21:1]));
                    end
                end
            end
            if (s_tvalid && s_tready)
                take_request(s_tuser, s_tdata);
        end
        pending = answers_due.size();
    end

endmodule

[verif/all_pairs_shortest_path_tb.sv]
// Testbench top for the all-pairs shortest path block: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module all_pairs_shortest_path_tb;

    import apsp_pkg::*;

    localparam int HOLD_CYCLES = 400;     // long receiver hold-off
    localparam int DRAIN_LIMIT = 20000;   // covers a full closure pass and then some
    localparam int SETTLE      = 20;

    // First matrix row: weight extremes and bit patterns, with no-edge entries
    localparam logic [15:0] ROW0 [16] = '{
        16'h0000, 16'hFFFF, 16'h0001, 16'h0000, 16'h8000, 16'h7FFF, 16'h00FF, 16'hFF00,
        16'h5555, 16'hAAAA, 16'h0002, 16'h0000, 16'h0003, 16'hFFFE, 16'h0000, 16'h0001
    };

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    int fail_count;
    int pending;

    bit calm         = 1'b0;   // no idling on either side
    bit rx_hold_go   = 1'b0;
    bit rx_hold_done = 1'b0;

    // Cells written so far; queries never touch an unwritten one
    bit cell_loaded [CELLS];
    int load_idx = 0;

    all_pairs_shortest_path DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    apsp_answer_checker answer_chk
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Offer one request, with an occasional idle burst first
    task automatic send_req(input logic op, input logic [15:0] w,
                            input logic [3:0] src, input logic [3:0] dst);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {dst, src, w};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (op == OP_LOAD)
        begin
            cell_loaded[load_idx] = 1'b1;
            load_idx = (load_idx + 1) % CELLS;
        end
    endtask

    // Unused node fields carry noise on loads
    task automatic load_weight(input logic [15:0] w);
        send_req(OP_LOAD, w, 4'($urandom), 4'($urandom));
    endtask

    // Unused weight field carries noise on queries
    task automatic ask_pair(input int src, input int dst);
        send_req(OP_QUERY, 16'($urandom), 4'(src), 4'(dst));
    endtask

    // Random pair, sometimes equal nodes, folded onto a written cell if need be
    task automatic ask_random();
        int src;
        int dst;
        int c;
        src = $urandom_range(0, NODES-1);
        dst = ($urandom_range(0, 7) == 0) ? src : $urandom_range(0, NODES-1);
        if (!cell_loaded[src*NODES + dst])
        begin
            c   = $urandom_range(0, load_idx - 1);
            src = c / NODES;
            dst = c % NODES;
        end
        ask_pair(src, dst);
    endtask

    // Sender stands idle until every answer has come back
    task automatic wait_drained();
        int n;
        n = 0;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0 && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
    endtask

    // Dense mix: no edge, short, longest and arbitrary weights
    function automatic logic [15:0] mixed_weight();
        case ($urandom_range(0, 5))
            0, 1:    mixed_weight = 16'h0000;
            2:       mixed_weight = 16'($urandom_range(1, 255));
            3:       mixed_weight = 16'hFFFF;
            default: mixed_weight = 16'($urandom);
        endcase
    endfunction

    // Forward chain of longest edges plus random backward edges: 0 to 15 spans the
    // whole chain, the largest distance there is
    function automatic logic [15:0] chain_weight(input int row, input int col);
        if (col == row + 1)
            chain_weight = 16'hFFFF;
        else if (col < row && $urandom_range(0, 3) == 0)
            chain_weight = 16'($urandom_range(1, 65535));
        else
            chain_weight = 16'h0000;
    endfunction

    // Receiver: random stalls, one long hold-off on request, none when calm
    initial
    begin
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (rx_hold_go && !rx_hold_done)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold_done = 1'b1;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // First row, then queries into the part-loaded matrix, equal nodes included
        foreach (ROW0[c])
            load_weight(ROW0[c]);
        ask_pair(0, 0);
        ask_pair(0, 1);
        ask_pair(0, 3);
        ask_pair(0, 15);
        ask_pair(0, 13);
        ask_pair(0, 2);

        // Rest of the first matrix with queries mixed in; closure follows the last load
        for (int n = NODES; n < CELLS; n++)
        begin
            if ($urandom_range(0, 5) == 0)
                ask_random();
            load_weight(mixed_weight());
        end
        ask_random();
        ask_random();
        wait_drained();

        // Receiver holds off while queries keep coming, so the block backs up
        rx_hold_go <= 1'b1;
        repeat (50) ask_random();

        // Second matrix wraps the load position; queries answer from the matrix as loaded so far
        for (int n = 0; n < CELLS; n++)
        begin
            if ($urandom_range(0, 7) == 0)
                ask_random();
            load_weight(chain_weight(n / NODES, n % NODES));
        end
        ask_pair(0, 15);
        ask_pair(15, 0);
        ask_pair(15, 15);
        ask_pair(7, 3);

        // Closing stretch at full rate
        calm <= 1'b1;
        repeat (40) ask_random();

        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Overall time limit
    initial
    begin
        #4000000;
        $display("status: fail");
        $finish;
    end

endmodule
